// ===== design/gapped_overlap_mismatch_scorer_core_assert.svh =====
// Assertion macros used by the scorer back end (gomsc_back).
// Depends on a clk and an active-low rst_n in the scope that uses them.
`ifndef GAPPED_OVERLAP_MISMATCH_SCORER_CORE_ASSERT_SVH
`define GAPPED_OVERLAP_MISMATCH_SCORER_CORE_ASSERT_SVH

// same-cycle implication
`define GOMSC_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define GOMSC_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== design/gomsc_pkg.sv =====
// Package for the gapped overlap mismatch scorer: sizes, constants and the
// site and result records passed between the modules. No dependencies.
package gomsc_pkg;

  localparam int MAX_SITES   = 65536;
  localparam int WEIGHT_BITS = 8;

  localparam int CODE_W = 8;
  localparam int WGT_W  = 8;
  localparam int OVL_W  = 17;
  localparam int PEN_W  = 24;

  localparam int POS_W  = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int IDX_W  = $clog2(MAX_SITES + 1);
  localparam int CALC_W = (POS_W + 1 > OVL_W) ? POS_W + 1 : OVL_W;

  localparam logic [CODE_W-1:0] GAP_RESET   = 8'd16;
  localparam logic [WGT_W-1:0]  WEIGHT_MASK =
    (WEIGHT_BITS >= WGT_W) ? {WGT_W{1'b1}} : WGT_W'((1 << WEIGHT_BITS) - 1);
  localparam logic [CALC_W-1:0] OVL_MAX = CALC_W'({OVL_W{1'b1}});
  localparam logic [PEN_W-1:0]  PEN_MAX = {PEN_W{1'b1}};

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             in_range;
    logic             fng;
    logic             png;
    logic             disjoint;
    logic [WGT_W-1:0] weight;
    logic             last;
  } site_t;

  typedef struct packed {
    logic [OVL_W-1:0] ovl;
    logic [PEN_W-1:0] pen;
  } result_t;

endpackage

// ===== design/gapped_overlap_mismatch_scorer_core.sv =====
// Top level of the gapped overlap mismatch scorer.
// Depends on gomsc_pkg, gomsc_front, gomsc_site_q and gomsc_back.
//
//   channel   direction  handshake        payload
//   in_*      input      in_push/in_full  full_code, part_code, site_weight, last_site
//   out_*     output     out_pop/out_empty overlap_len, penalty_sum
//   cfg_*     input      cfg_wr_en        cfg_wr_data (gap code)
//
// One site per cycle sustained while the output is not stalled; a site passes
// through the site queue to the back end, and its result, on the last site,
// is written to the result queue, which drives the output. Penalty add and snapshot are combinational.
// Reset is synchronous: no clearing pass, the gap code returns to 16.
// Output stalls fill the two-entry result queue, then the two-entry site queue,
// then raise in_full.
module gapped_overlap_mismatch_scorer_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [gomsc_pkg::CODE_W-1:0] cfg_wr_data,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [gomsc_pkg::CODE_W-1:0] in_full_code,
  input  logic [gomsc_pkg::CODE_W-1:0] in_part_code,
  input  logic [gomsc_pkg::WGT_W-1:0]  in_site_weight,
  input  logic                        in_last_site,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [gomsc_pkg::OVL_W-1:0] out_overlap_len,
  output logic [gomsc_pkg::PEN_W-1:0] out_penalty_sum
);
  import gomsc_pkg::*;

  site_t q_wdata, q_rdata;
  logic  q_wr, q_full, q_valid, q_rd;

  gomsc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_full_code   (in_full_code),
    .in_part_code   (in_part_code),
    .in_site_weight (in_site_weight),
    .in_last_site   (in_last_site),
    .q_full         (q_full),
    .q_wr           (q_wr),
    .q_wdata        (q_wdata)
  );

  gomsc_site_q u_site_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .valid (q_valid),
    .rd    (q_rd),
    .rdata (q_rdata)
  );

  gomsc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_rdata         (q_rdata),
    .q_rd            (q_rd),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_overlap_len (out_overlap_len),
    .out_penalty_sum (out_penalty_sum)
  );

endmodule

// ===== design/gomsc_front.sv =====
// Front end: gap register, site counter and per-site classification.
// Depends on gomsc_pkg; feeds gomsc_site_q.
module gomsc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [gomsc_pkg::CODE_W-1:0] cfg_wr_data,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [gomsc_pkg::CODE_W-1:0] in_full_code,
  input  logic [gomsc_pkg::CODE_W-1:0] in_part_code,
  input  logic [gomsc_pkg::WGT_W-1:0]  in_site_weight,
  input  logic                        in_last_site,
  input  logic                        q_full,
  output logic                        q_wr,
  output gomsc_pkg::site_t            q_wdata
);
  import gomsc_pkg::*;

  logic [CODE_W-1:0] gap_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              in_range;

  assign in_full  = q_full;
  assign q_wr     = in_push && !q_full;
  assign in_range = idx_r < IDX_W'(MAX_SITES);

  always_comb begin
    q_wdata.pos      = idx_r[POS_W-1:0];
    q_wdata.in_range = in_range;
    q_wdata.fng      = in_full_code != gap_r;
    q_wdata.png      = in_part_code != gap_r;
    q_wdata.disjoint = (in_full_code & in_part_code) == '0;
    q_wdata.weight   = in_site_weight & WEIGHT_MASK;
    q_wdata.last     = in_last_site;
  end

  always_comb begin
    idx_nxt = idx_r;
    if (q_wr) begin
      if (in_last_site) begin
        idx_nxt = '0;
      end else if (in_range) begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= GAP_RESET;
      idx_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        gap_r <= cfg_wr_data;
      end
      idx_r <= idx_nxt;
    end
  end

endmodule

// ===== design/gomsc_site_q.sv =====
// Two-entry queue of classified sites between front and back.
// Depends on gomsc_pkg.
module gomsc_site_q (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  gomsc_pkg::site_t wdata,
  output logic             full,
  output logic             valid,
  input  logic             rd,
  output gomsc_pkg::site_t rdata
);
  import gomsc_pkg::*;

  site_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, rp_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign valid = cnt_r != '0;
  assign rdata = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + Q_PTR_W'(1);
      end
      if (rd) begin
        rp_r <= rp_r + Q_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== design/gomsc_back.sv =====
// Back end: overlap tracking, saturating penalty, snapshots, result queue.
// Depends on gomsc_pkg and the assertion macro header.
module gomsc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  gomsc_pkg::site_t           q_rdata,
  output logic                       q_rd,
  input  logic                       out_pop,
  output logic                       out_empty,
  output logic [gomsc_pkg::OVL_W-1:0] out_overlap_len,
  output logic [gomsc_pkg::PEN_W-1:0] out_penalty_sum
);
  import gomsc_pkg::*;
  `include "gapped_overlap_mismatch_scorer_core_assert.svh"

  logic [POS_W-1:0] ff_r, ff_nxt, ff_u;
  logic [POS_W-1:0] pf_r, pf_nxt, pf_u;
  logic [POS_W-1:0] fl_r, fl_nxt, fl_u;
  logic [POS_W-1:0] pl_r, pl_nxt, pl_u;
  logic [1:0]       seen_r, seen_nxt, seen_u;
  logic [PEN_W-1:0] run_r, run_nxt, run_u;
  logic [PEN_W-1:0] mkf_r, mkf_nxt, mkf_u;
  logic [PEN_W-1:0] mkp_r, mkp_nxt, mkp_u;

  logic [PEN_W:0]    pen_sum;
  logic [PEN_W-1:0]  pen_sat;
  logic [POS_W-1:0]  span_start, span_end;
  logic              full_ends_first;
  logic [CALC_W-1:0] span_len;
  result_t           res;

  result_t            res_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] res_wp_r, res_rp_r;
  logic [Q_CNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic               res_full, res_wr, res_rd;

  assign res_full = res_cnt_r == Q_CNT_W'(Q_DEPTH);
  assign q_rd     = q_valid && (!q_rdata.last || !res_full);
  assign res_wr   = q_rd && q_rdata.last;
  assign res_rd   = out_pop && !out_empty;

  assign pen_sum = {1'b0, run_r} + (PEN_W + 1)'(q_rdata.weight);
  assign pen_sat = pen_sum[PEN_W] ? PEN_MAX : pen_sum[PEN_W-1:0];

  always_comb begin
    ff_u   = ff_r;
    pf_u   = pf_r;
    fl_u   = fl_r;
    pl_u   = pl_r;
    seen_u = seen_r;
    run_u  = run_r;
    mkf_u  = mkf_r;
    mkp_u  = mkp_r;
    if (q_rdata.in_range) begin
      if (q_rdata.fng && !seen_r[0]) begin
        ff_u = q_rdata.pos;
      end
      if (q_rdata.png && !seen_r[1]) begin
        pf_u = q_rdata.pos;
      end
      seen_u = seen_r | {q_rdata.png, q_rdata.fng};
      if (seen_u == 2'b11 && q_rdata.disjoint) begin
        run_u = pen_sat;
      end
      if (q_rdata.fng) begin
        fl_u  = q_rdata.pos;
        mkf_u = run_u;
      end
      if (q_rdata.png) begin
        pl_u  = q_rdata.pos;
        mkp_u = run_u;
      end
    end
  end

  always_comb begin
    span_start      = (ff_u > pf_u) ? ff_u : pf_u;
    full_ends_first = fl_u <= pl_u;
    span_end        = full_ends_first ? fl_u : pl_u;
    span_len        = CALC_W'(span_end) - CALC_W'(span_start) + CALC_W'(1);
    res.ovl = '0;
    res.pen = '0;
    if (seen_u == 2'b11 && span_end >= span_start) begin
      res.ovl = (span_len > OVL_MAX) ? OVL_MAX[OVL_W-1:0] : span_len[OVL_W-1:0];
      res.pen = full_ends_first ? mkf_u : mkp_u;
    end
  end

  always_comb begin
    ff_nxt   = ff_r;
    pf_nxt   = pf_r;
    fl_nxt   = fl_r;
    pl_nxt   = pl_r;
    seen_nxt = seen_r;
    run_nxt  = run_r;
    mkf_nxt  = mkf_r;
    mkp_nxt  = mkp_r;
    if (q_rd) begin
      if (q_rdata.last) begin
        ff_nxt   = '0;
        pf_nxt   = '0;
        fl_nxt   = '0;
        pl_nxt   = '0;
        seen_nxt = '0;
        run_nxt  = '0;
        mkf_nxt  = '0;
        mkp_nxt  = '0;
      end else begin
        ff_nxt   = ff_u;
        pf_nxt   = pf_u;
        fl_nxt   = fl_u;
        pl_nxt   = pl_u;
        seen_nxt = seen_u;
        run_nxt  = run_u;
        mkf_nxt  = mkf_u;
        mkp_nxt  = mkp_u;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_r   <= '0;
      pf_r   <= '0;
      fl_r   <= '0;
      pl_r   <= '0;
      seen_r <= '0;
      run_r  <= '0;
      mkf_r  <= '0;
      mkp_r  <= '0;
    end else begin
      ff_r   <= ff_nxt;
      pf_r   <= pf_nxt;
      fl_r   <= fl_nxt;
      pl_r   <= pl_nxt;
      seen_r <= seen_nxt;
      run_r  <= run_nxt;
      mkf_r  <= mkf_nxt;
      mkp_r  <= mkp_nxt;
    end
  end

  assign out_empty       = res_cnt_r == '0;
  assign out_overlap_len = res_mem_r[res_rp_r].ovl;
  assign out_penalty_sum = res_mem_r[res_rp_r].pen;

  always_comb begin
    res_cnt_nxt = res_cnt_r;
    if (res_wr && !res_rd) begin
      res_cnt_nxt = res_cnt_r + Q_CNT_W'(1);
    end else if (res_rd && !res_wr) begin
      res_cnt_nxt = res_cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (res_wr) begin
      res_mem_r[res_wp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wp_r  <= '0;
      res_rp_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      if (res_wr) begin
        res_wp_r <= res_wp_r + Q_PTR_W'(1);
      end
      if (res_rd) begin
        res_rp_r <= res_rp_r + Q_PTR_W'(1);
      end
      res_cnt_r <= res_cnt_nxt;
    end
  end

  `GOMSC_ASSERT_NEXT(a_clear_after_last, q_rd && q_rdata.last, seen_r == 2'b00 && run_r == '0, "state not cleared after last site")
  `GOMSC_ASSERT_NOW(a_pen_needs_overlap, !out_empty && out_penalty_sum != '0, out_overlap_len != '0, "penalty without overlap")
  `GOMSC_ASSERT_NEXT(a_full_last_mark, q_rd && !q_rdata.last && q_rdata.in_range && q_rdata.fng, fl_r == $past(q_rdata.pos) && mkf_r == run_r, "full sequence last mark not taken")
  `GOMSC_ASSERT_NOW(a_res_no_overrun, res_wr, !res_full || res_rd, "result queue overrun")

endmodule

// ===== verif/gomsc_score_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for gapped_overlap_mismatch_scorer_core: tracks gap code writes,
// predicts overlap and penalty per sequence pair, and compares popped results.
// Depends on gomsc_pkg for widths, limits and the result record.
module gomsc_score_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [gomsc_pkg::CODE_W-1:0] cfg_wr_data,
  input  logic                         in_push,
  input  logic                         in_full,
  input  logic [gomsc_pkg::CODE_W-1:0] in_full_code,
  input  logic [gomsc_pkg::CODE_W-1:0] in_part_code,
  input  logic [gomsc_pkg::WGT_W-1:0]  in_site_weight,
  input  logic                         in_last_site,
  input  logic                         out_empty,
  input  logic                         out_pop,
  input  logic [gomsc_pkg::OVL_W-1:0]  out_overlap_len,
  input  logic [gomsc_pkg::PEN_W-1:0]  out_penalty_sum,
  output int unsigned                  score_errors,
  output int unsigned                  scores_due
);
  import gomsc_pkg::*;

  logic [CODE_W-1:0] gap_val;
  logic [IDX_W-1:0]  site_idx;
  logic [POS_W-1:0]  full_lo, part_lo, full_hi, part_hi;
  logic [1:0]        seen;
  logic [PEN_W-1:0]  run_pen;
  logic [PEN_W-1:0]  pen_snap [2];
  result_t           score_q [$];
  int unsigned       err_n;

  initial begin
    err_n = 0;
  end

  always @(posedge clk) begin : track
    logic             fng, png, full_ends;
    logic [POS_W-1:0] pos, span_lo, span_hi;
    logic [PEN_W:0]   pen_sum;
    result_t          want;
    if (!rst_n) begin
      gap_val  = GAP_RESET;
      site_idx = '0;
      full_lo  = '0;
      part_lo  = '0;
      full_hi  = '0;
      part_hi  = '0;
      seen     = '0;
      run_pen  = '0;
      pen_snap[0] = '0;
      pen_snap[1] = '0;
      score_q.delete();
    end else begin
      if (cfg_wr_en) gap_val = cfg_wr_data;

      if (out_pop && !out_empty) begin
        if (score_q.size() == 0) begin
          err_n++;
          $display("%0t: unexpected result, expected none, actual overlap_len %0d penalty_sum %0d",
                   $time, out_overlap_len, out_penalty_sum);
        end else begin
          want = score_q.pop_front();
          if (out_overlap_len !== want.ovl) begin
            err_n++;
            $display("%0t: overlap_len mismatch, expected %0d, actual %0d",
                     $time, want.ovl, out_overlap_len);
          end
          if (out_penalty_sum !== want.pen) begin
            err_n++;
            $display("%0t: penalty_sum mismatch, expected %0d, actual %0d",
                     $time, want.pen, out_penalty_sum);
          end
        end
      end

      if (in_push && !in_full) begin
        if (site_idx < MAX_SITES) begin
          pos = site_idx[POS_W-1:0];
          fng = in_full_code != gap_val;
          png = in_part_code != gap_val;
          if (fng && !seen[0]) full_lo = pos;
          if (png && !seen[1]) part_lo = pos;
          seen = seen | {png, fng};
          if (seen == 2'b11 && (in_full_code & in_part_code) == '0) begin
            pen_sum = run_pen + (in_site_weight & WEIGHT_MASK);
            run_pen = (pen_sum > PEN_MAX) ? PEN_MAX : pen_sum[PEN_W-1:0];
          end
          if (fng) begin
            full_hi     = pos;
            pen_snap[0] = run_pen;
          end
          if (png) begin
            part_hi     = pos;
            pen_snap[1] = run_pen;
          end
          site_idx = site_idx + 1'b1;
        end
        if (in_last_site) begin
          want = '0;
          if (seen == 2'b11) begin
            span_lo   = (full_lo > part_lo) ? full_lo : part_lo;
            full_ends = full_hi <= part_hi;
            span_hi   = full_ends ? full_hi : part_hi;
            if (span_hi >= span_lo) begin
              want.ovl = OVL_W'(span_hi - span_lo) + OVL_W'(1);
              want.pen = full_ends ? pen_snap[0] : pen_snap[1];
            end
          end
          score_q.push_back(want);
          site_idx = '0;
          full_lo  = '0;
          part_lo  = '0;
          full_hi  = '0;
          part_hi  = '0;
          seen     = '0;
          run_pen  = '0;
          pen_snap[0] = '0;
          pen_snap[1] = '0;
        end
      end
    end
    scores_due   <= score_q.size();
    score_errors <= err_n;
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the scorer testbench: clock, reset, gap code writes and site stimulus
// under several idle and stall mixes. Depends on gomsc_pkg, the scorer core
// and gomsc_score_checker, which predicts and compares the results.
module tb_top;
  import gomsc_pkg::*;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              cfg_wr_en      = 1'b0;
  logic [CODE_W-1:0] cfg_wr_data    = '0;
  logic              in_push        = 1'b0;
  logic [CODE_W-1:0] in_full_code   = '0;
  logic [CODE_W-1:0] in_part_code   = '0;
  logic [WGT_W-1:0]  in_site_weight = '0;
  logic              in_last_site   = 1'b0;
  logic              out_pop        = 1'b0;
  logic              in_full;
  logic              out_empty;
  logic [OVL_W-1:0]  out_overlap_len;
  logic [PEN_W-1:0]  out_penalty_sum;
  int unsigned       score_errors;
  int unsigned       scores_due;

  int          idle_pct  = 0;
  int          stall_pct = 0;
  logic [7:0]  cur_gap   = GAP_RESET;

  always #10 clk = ~clk;

  gapped_overlap_mismatch_scorer_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_full_code    (in_full_code),
    .in_part_code    (in_part_code),
    .in_site_weight  (in_site_weight),
    .in_last_site    (in_last_site),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_overlap_len (out_overlap_len),
    .out_penalty_sum (out_penalty_sum)
  );

  gomsc_score_checker score_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_full_code    (in_full_code),
    .in_part_code    (in_part_code),
    .in_site_weight  (in_site_weight),
    .in_last_site    (in_last_site),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_overlap_len (out_overlap_len),
    .out_penalty_sum (out_penalty_sum),
    .score_errors    (score_errors),
    .scores_due      (scores_due)
  );

  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #40_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  task automatic set_mode(input int m);
    case (m)
      0: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      1: begin
        idle_pct  = 79;
        stall_pct = 0;
      end
      2: begin
        idle_pct  = 0;
        stall_pct = 79;
      end
      default: begin
        idle_pct  = 33;
        stall_pct = 33;
      end
    endcase
  endtask

  task automatic send_site(input logic [7:0] f, input logic [7:0] p,
                           input logic [7:0] w, input logic l);
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push        <= 1'b1;
    in_full_code   <= f;
    in_part_code   <= p;
    in_site_weight <= w;
    in_last_site   <= l;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // drop push, then wait until all expected results are drained
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (scores_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_gap(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    cur_gap      = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] base_code();
    if ($urandom_range(1) == 0) return 8'h01 << $urandom_range(7);
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] any_code();
    if ($urandom_range(9) < 3) return cur_gap;
    return base_code();
  endfunction

  function automatic logic [7:0] pick_weight();
    case ($urandom_range(9))
      0:       return 8'h00;
      1, 2:    return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // non-gap windows per sequence with gaps around them; noise pairs are unstructured
  task automatic send_pair(input int len, input bit noise);
    int         f_lo, f_hi, p_lo, p_hi, i;
    logic [7:0] f, p;
    f_lo = $urandom_range(len - 1);
    f_hi = $urandom_range(len - 1, f_lo);
    p_lo = $urandom_range(len - 1);
    p_hi = $urandom_range(len - 1, p_lo);
    if ($urandom_range(99) < 8) f_lo = len;
    if ($urandom_range(99) < 8) p_lo = len;
    for (i = 0; i < len; i++) begin
      if (noise) begin
        f = any_code();
        p = any_code();
      end else begin
        f = (i >= f_lo && i <= f_hi && $urandom_range(9) != 0) ? base_code() : cur_gap;
        p = (i >= p_lo && i <= p_hi && $urandom_range(9) != 0) ? base_code() : cur_gap;
      end
      send_site(f, p, pick_weight(), i == len - 1);
    end
  endtask

  initial begin
    logic [7:0] gap_list [8];
    int         ph, cnt, len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gap code, single-site pairs, gaps on one or both sides, empty span
    set_mode(0);
    send_site(8'h01, 8'h02, 8'hFF, 1'b1);
    send_site(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_site(8'd16, 8'h01, 8'h07, 1'b1);
    send_site(8'd16, 8'd16, 8'h09, 1'b1);
    send_site(8'h01, 8'd16, 8'h05, 1'b0);
    send_site(8'h02, 8'd16, 8'h05, 1'b0);
    send_site(8'd16, 8'h04, 8'h05, 1'b0);
    send_site(8'd16, 8'h08, 8'h05, 1'b1);
    send_site(8'h00, 8'hFF, 8'hC8, 1'b0);
    send_site(8'hFF, 8'h00, 8'h64, 1'b0);
    send_site(8'h00, 8'h00, 8'h32, 1'b0);
    send_site(8'd16, 8'h03, 8'h01, 1'b0);
    send_site(8'h04, 8'd16, 8'h4D, 1'b1);
    send_site(8'h01, 8'h02, 8'h00, 1'b1);
    settle();
    write_gap(8'h00);
    send_site(8'h00, 8'h05, 8'h1E, 1'b0);
    send_site(8'h01, 8'h02, 8'h28, 1'b0);
    send_site(8'h00, 8'h00, 8'h3C, 1'b1);
    settle();
    write_gap(8'hFF);
    send_site(8'hFF, 8'hFF, 8'h01, 1'b0);
    send_site(8'h01, 8'hFF, 8'h09, 1'b0);
    send_site(8'hFF, 8'h02, 8'h08, 1'b1);
    settle();

    gap_list = '{8'h00, 8'hFF, 8'd16, 8'h01, 8'h80, 8'h00, 8'hFE, 8'h7F};
    gap_list[5] = 8'($urandom_range(255));
    gap_list[7] = 8'($urandom_range(255));
    for (ph = 0; ph < 8; ph++) begin
      write_gap(gap_list[ph]);
      set_mode(ph % 4);
      cnt = 0;
      while (cnt < 240) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(16, 1);
        send_pair(len, $urandom_range(4) == 0);
        cnt += len;
      end
      settle();
    end

    if (score_errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
